@@ rtl/rec_pkg.sv @@
// shared widths, constants and control structs for the row error compare core
package rec_pkg;

    localparam int LOGIT_W        = 16;
    localparam int MAX_ROW_LENGTH = 65536;
    localparam int CNT_W          = $clog2(MAX_ROW_LENGTH);
    localparam int LEN_W          = CNT_W + 1;
    localparam int SQ_W           = 2 * LOGIT_W;
    localparam int SUM_W          = 48;
    localparam int MSE_W          = 32;
    localparam int PEAK_W         = LOGIT_W;
    localparam int DIV_STEPS      = SUM_W;
    localparam int STEP_W         = $clog2(DIV_STEPS);
    localparam int IN_TDATA_W     = 2 * LOGIT_W;
    localparam int OUT_W          = MSE_W + PEAK_W + 1;
    localparam int OUT_TDATA_W    = ((OUT_W + 7) / 8) * 8;

    localparam logic [LEN_W-1:0] ROW_LEN_RESET = LEN_W'(MAX_ROW_LENGTH);
    localparam logic [LEN_W-1:0] ROW_LEN_MAX   = LEN_W'(MAX_ROW_LENGTH);

    typedef struct packed {
        logic row_end;
    } t_sts;

    typedef struct packed {
        logic accept;
        logic last;
        logic s2_valid;
        logic div_start;
        logic div_step;
        logic out_load;
    } t_cmd;

endpackage

@@ rtl/rec_ctrl.sv @@
// controller: input handshake, pipeline valids, divider sequencing and output valid
module rec_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_valid,
    output logic          o_s_ready,
    input  rec_pkg::t_sts i_sts,
    output rec_pkg::t_cmd o_cmd,
    output logic          o_m_valid,
    input  logic          i_m_ready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]                  r_state, n_state;
    logic [rec_pkg::STEP_W-1:0]  r_cnt, n_cnt;
    logic                        r_s1_v, r_s1_last, r_s2_v, r_s2_last;
    logic                        r_resv;
    logic                        r_m_valid;
    logic                        w_ready;
    rec_pkg::t_cmd               w_cmd;

    // a row end waits while the previous row still owns the divider
    assign w_ready = !(r_resv && i_sts.row_end);

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        w_cmd.accept   = i_s_valid && w_ready;
        w_cmd.last     = i_s_valid && w_ready && i_sts.row_end;
        w_cmd.s2_valid = r_s2_v;
        w_cmd.div_start = 1'b0;
        w_cmd.div_step = 1'b0;
        w_cmd.out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (r_s2_v && r_s2_last) begin
                    w_cmd.div_start = 1'b1;
                    n_state = ST_BUSY;
                    n_cnt   = '0;
                end
            end
            ST_BUSY: begin
                w_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == rec_pkg::STEP_W'(rec_pkg::DIV_STEPS - 1)) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (!r_m_valid || i_m_ready) begin
                    w_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_s1_v    <= 1'b0;
            r_s1_last <= 1'b0;
            r_s2_v    <= 1'b0;
            r_s2_last <= 1'b0;
            r_resv    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_s1_v    <= w_cmd.accept;
            r_s1_last <= w_cmd.last;
            r_s2_v    <= r_s1_v;
            r_s2_last <= r_s1_last;
            if (w_cmd.last) begin
                r_resv <= 1'b1;
            end else if (w_cmd.out_load) begin
                r_resv <= 1'b0;
            end
            if (w_cmd.out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_s_ready = w_ready;
    assign o_cmd     = w_cmd;
    assign o_m_valid = r_m_valid;

endmodule

@@ rtl/rec_acc.sv @@
// datapath: row length register, running maxima, squaring pipeline and sum accumulator
module rec_acc (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rec_pkg::LEN_W-1:0]     i_cfg_data,
    input  logic [rec_pkg::IN_TDATA_W-1:0] i_data,
    input  rec_pkg::t_cmd                 i_cmd,
    output rec_pkg::t_sts                 o_sts,
    output logic [rec_pkg::LEN_W-1:0]     o_len_eff,
    output logic [rec_pkg::SUM_W-1:0]     o_sum_final,
    output logic [rec_pkg::PEAK_W-1:0]    o_peak,
    output logic                          o_match
);

    localparam int LW = rec_pkg::LOGIT_W;

    logic [rec_pkg::LEN_W-1:0]  r_len;
    logic [rec_pkg::CNT_W-1:0]  r_count;
    logic [rec_pkg::SUM_W-1:0]  r_sum;
    logic [rec_pkg::PEAK_W-1:0] r_peak;
    logic signed [LW-1:0]       r_ref_top, r_cand_top;
    logic [rec_pkg::CNT_W-1:0]  r_ref_idx, r_cand_idx;

    logic [rec_pkg::PEAK_W-1:0] r_s1_mag, r_s1_peak, r_s2_peak;
    logic                       r_s1_match, r_s2_match;
    logic [rec_pkg::SQ_W-1:0]   r_s2_sq;

    logic [rec_pkg::LEN_W-1:0]  w_len_eff, w_pos1;
    logic signed [LW-1:0]       w_ref, w_cand;
    logic signed [LW:0]         w_diff, w_neg;
    logic [rec_pkg::PEAK_W-1:0] w_mag, n_peak;
    logic                       w_first;
    logic signed [LW-1:0]       n_ref_top, n_cand_top;
    logic [rec_pkg::CNT_W-1:0]  n_ref_idx, n_cand_idx;
    logic [rec_pkg::SUM_W:0]    w_add;
    logic [rec_pkg::SUM_W-1:0]  w_sum_sat;

    always_comb begin
        if (r_len == '0) begin
            w_len_eff = rec_pkg::LEN_W'(1);
        end else if (r_len > rec_pkg::ROW_LEN_MAX) begin
            w_len_eff = rec_pkg::ROW_LEN_MAX;
        end else begin
            w_len_eff = r_len;
        end
        w_pos1 = {1'b0, r_count} + rec_pkg::LEN_W'(1);

        w_ref  = signed'(i_data[LW-1:0]);
        w_cand = signed'(i_data[2*LW-1:LW]);
        w_diff = {w_cand[LW-1], w_cand} - {w_ref[LW-1], w_ref};
        w_neg  = -w_diff;
        // |diff| never exceeds the unsigned logit range
        w_mag  = w_diff[LW] ? w_neg[LW-1:0] : w_diff[LW-1:0];
        n_peak = (w_mag > r_peak) ? w_mag : r_peak;

        // first pair of a row seeds both maxima at index zero
        w_first    = (r_count == '0);
        n_ref_top  = r_ref_top;
        n_ref_idx  = r_ref_idx;
        n_cand_top = r_cand_top;
        n_cand_idx = r_cand_idx;
        if (w_first || (w_ref > r_ref_top)) begin
            n_ref_top = w_ref;
            n_ref_idx = r_count;
        end
        if (w_first || (w_cand > r_cand_top)) begin
            n_cand_top = w_cand;
            n_cand_idx = r_count;
        end

        w_add     = {1'b0, r_sum} + (rec_pkg::SUM_W + 1)'(r_s2_sq);
        w_sum_sat = w_add[rec_pkg::SUM_W] ? '1 : w_add[rec_pkg::SUM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= rec_pkg::ROW_LEN_RESET;
            r_count    <= '0;
            r_sum      <= '0;
            r_peak     <= '0;
            r_ref_top  <= '0;
            r_ref_idx  <= '0;
            r_cand_top <= '0;
            r_cand_idx <= '0;
        end else begin
            if (i_cfg_we) begin
                r_len <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                if (i_cmd.last) begin
                    r_count    <= '0;
                    r_peak     <= '0;
                    r_ref_top  <= '0;
                    r_ref_idx  <= '0;
                    r_cand_top <= '0;
                    r_cand_idx <= '0;
                end else begin
                    r_count    <= w_pos1[rec_pkg::CNT_W-1:0];
                    r_peak     <= n_peak;
                    r_ref_top  <= n_ref_top;
                    r_ref_idx  <= n_ref_idx;
                    r_cand_top <= n_cand_top;
                    r_cand_idx <= n_cand_idx;
                end
            end
            if (i_cmd.s2_valid) begin
                r_sum <= i_cmd.div_start ? '0 : w_sum_sat;
            end
        end
    end

    // squaring pipeline, the row-end snapshot rides along
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_s1_mag   <= w_mag;
            r_s1_peak  <= n_peak;
            r_s1_match <= (n_ref_idx == n_cand_idx);
        end
        r_s2_sq    <= r_s1_mag * r_s1_mag;
        r_s2_peak  <= r_s1_peak;
        r_s2_match <= r_s1_match;
    end

    assign o_sts.row_end = (w_pos1 >= w_len_eff);
    assign o_len_eff     = w_len_eff;
    assign o_sum_final   = w_sum_sat;
    assign o_peak        = r_s2_peak;
    assign o_match       = r_s2_match;

endmodule

@@ rtl/rec_div.sv @@
// datapath: bit-serial restoring divider for the row mean and the output register
module rec_div (
    input  logic                       i_clk,
    input  rec_pkg::t_cmd              i_cmd,
    input  logic [rec_pkg::SUM_W-1:0]  i_dividend,
    input  logic [rec_pkg::LEN_W-1:0]  i_divisor,
    input  logic [rec_pkg::PEAK_W-1:0] i_peak,
    input  logic                       i_match,
    output logic [rec_pkg::MSE_W-1:0]  o_mse,
    output logic [rec_pkg::PEAK_W-1:0] o_peak,
    output logic                       o_match
);

    localparam int SW = rec_pkg::SUM_W;
    localparam int NW = rec_pkg::LEN_W;

    logic [SW-1:0]              r_quo;
    logic [NW-1:0]              r_rem, r_div;
    logic [rec_pkg::PEAK_W-1:0] r_peak, r_out_peak;
    logic                       r_match, r_out_match;
    logic [rec_pkg::MSE_W-1:0]  r_out_mse;

    logic [NW:0]                w_trial, w_sub;
    logic                       w_ge;
    logic [rec_pkg::MSE_W-1:0]  w_mse_sat;

    always_comb begin
        w_trial = {r_rem, r_quo[SW-1]};
        w_sub   = w_trial - {1'b0, r_div};
        w_ge    = (w_trial >= {1'b0, r_div});
        w_mse_sat = (|r_quo[SW-1:rec_pkg::MSE_W]) ? '1 : r_quo[rec_pkg::MSE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_quo   <= i_dividend;
            r_rem   <= '0;
            r_div   <= i_divisor;
            r_peak  <= i_peak;
            r_match <= i_match;
        end else if (i_cmd.div_step) begin
            // remainder stays below the divisor, so it fits the divisor width
            r_rem <= w_ge ? w_sub[NW-1:0] : w_trial[NW-1:0];
            r_quo <= {r_quo[SW-2:0], w_ge};
        end
        if (i_cmd.out_load) begin
            r_out_mse   <= w_mse_sat;
            r_out_peak  <= r_peak;
            r_out_match <= r_match;
        end
    end

    assign o_mse   = r_out_mse;
    assign o_peak  = r_out_peak;
    assign o_match = r_out_match;

endmodule

@@ rtl/row_error_and_argmax_compare_core.sv @@
// top level of the row error and argmax agreement core
//
// One reference/candidate logit pair (signed Q8.8) enters per clock. Over a row of
// row_length pairs (0 acts as 1, values above 65536 act as 65536) the core sums the
// squared differences, keeps the largest absolute difference and the first argmax of
// each vector. A row yields one result transaction: the mean squared error (sum / row
// length, truncated, Q16.16), the peak absolute error and an argmax agreement flag.
// The mean comes from a bit-serial divider that produces one quotient bit per clock.
// Pairs keep streaming while the divider works; the input only stalls on the last pair
// of a row while the previous row's result has not yet moved into the output register.
// Rows of 52 or more pairs therefore run at one pair per clock while results are taken
// promptly. Write row_length only while idle.
module row_error_and_argmax_compare_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rec_pkg::LEN_W-1:0]           i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // ref_logit [15:0], cand_logit [31:16]
    input  logic [rec_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // mean_sq_error [31:0], max_abs_error [47:32], top_match [48], zero fill above
    output logic [rec_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    rec_pkg::t_cmd              w_cmd;
    rec_pkg::t_sts              w_sts;
    logic [rec_pkg::LEN_W-1:0]  w_len_eff;
    logic [rec_pkg::SUM_W-1:0]  w_sum_final;
    logic [rec_pkg::PEAK_W-1:0] w_s2_peak, w_out_peak;
    logic                       w_s2_match, w_out_match;
    logic [rec_pkg::MSE_W-1:0]  w_out_mse;

    assign o_cfg_ready = 1'b1;

    rec_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready)
    );

    rec_acc u_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_data      (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_len_eff   (w_len_eff),
        .o_sum_final (w_sum_final),
        .o_peak      (w_s2_peak),
        .o_match     (w_s2_match)
    );

    rec_div u_div (
        .i_clk      (i_clk),
        .i_cmd      (w_cmd),
        .i_dividend (w_sum_final),
        .i_divisor  (w_len_eff),
        .i_peak     (w_s2_peak),
        .i_match    (w_s2_match),
        .o_mse      (w_out_mse),
        .o_peak     (w_out_peak),
        .o_match    (w_out_match)
    );

    assign m_axis_tdata = {{(rec_pkg::OUT_TDATA_W - rec_pkg::OUT_W){1'b0}},
                           w_out_match, w_out_peak, w_out_mse};

`ifndef SYNTHESIS
    // a new row reaches the divider only when it is idle
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |-> (!w_cmd.div_step && !w_cmd.out_load))
        else $error("divider started while busy");

    // the divider begins stepping right after it is loaded
    a_start_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |=> w_cmd.div_step)
        else $error("divider did not step after start");

    // a loaded result is offered on the output the next cycle
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> m_axis_tvalid)
        else $error("loaded result not presented");

    // no two row ends are taken back to back, as the earlier row still holds the divider
    a_one_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.last |=> !w_cmd.last)
        else $error("two row ends accepted back to back");
`endif

endmodule

@@ tb/sv/row_error_checker.sv @@
`timescale 1ns / 1ps
// checker for the row error core: predicts each row result from the input stream and compares
module row_error_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [rec_pkg::LEN_W-1:0]           i_cfg_data,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    // ref_logit [15:0], cand_logit [31:16]
    input  logic [rec_pkg::IN_TDATA_W-1:0]      i_in_data,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    // mean_sq_error [31:0], max_abs_error [47:32], top_match [48], zero fill above
    input  logic [rec_pkg::OUT_TDATA_W-1:0]     i_out_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    localparam int LW = rec_pkg::LOGIT_W;
    localparam longint unsigned SUM_LIMIT = (64'd1 << rec_pkg::SUM_W) - 64'd1;
    localparam longint unsigned MSE_LIMIT = (64'd1 << rec_pkg::MSE_W) - 64'd1;
    localparam int unsigned PEAK_LIMIT    = (1 << rec_pkg::PEAK_W) - 1;

    typedef struct packed {
        logic [rec_pkg::MSE_W-1:0]  mse;
        logic [rec_pkg::PEAK_W-1:0] peak;
        logic                       match;
    } t_row_result;

    t_row_result               row_results_q[$];
    logic [rec_pkg::LEN_W-1:0] row_len;
    int unsigned               pair_count;
    longint unsigned           sq_sum;
    int unsigned               abs_peak;
    logic signed [LW-1:0]      ref_top;
    logic signed [LW-1:0]      cand_top;
    int unsigned               ref_idx;
    int unsigned               cand_idx;

    always @(posedge i_clk) begin : predict
        logic signed [LW-1:0] ref_val;
        logic signed [LW-1:0] cand_val;
        int                   diff;
        int unsigned          mag;
        longint unsigned      mag_wide;
        longint unsigned      sq;
        longint unsigned      mean;
        int unsigned          eff_len;
        t_row_result          expected;
        t_row_result          got;

        if (!i_rst_n) begin
            o_fail_count = 0;
            row_len = rec_pkg::ROW_LEN_RESET;
            pair_count = 0;
            sq_sum = 0;
            abs_peak = 0;
            ref_top = '0;
            cand_top = '0;
            ref_idx = 0;
            cand_idx = 0;
            row_results_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got.mse   = i_out_data[rec_pkg::MSE_W-1:0];
                got.peak  = i_out_data[rec_pkg::MSE_W +: rec_pkg::PEAK_W];
                got.match = i_out_data[rec_pkg::MSE_W + rec_pkg::PEAK_W];
                if (row_results_q.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("unexpected row result: mse %0d peak %0d match %0d",
                                 got.mse, got.peak, got.match);
                    end
                    o_fail_count++;
                end else begin
                    expected = row_results_q.pop_front();
                    if (got.mse !== expected.mse || got.peak !== expected.peak ||
                        got.match !== expected.match) begin
                        if (o_fail_count < 10) begin
                            $display({"row result mismatch: expected mse %0d peak %0d",
                                      " match %0d, got mse %0d peak %0d match %0d"},
                                     expected.mse, expected.peak, expected.match,
                                     got.mse, got.peak, got.match);
                        end
                        o_fail_count++;
                    end
                end
            end

            if (i_cfg_valid && i_cfg_ready) begin
                row_len = i_cfg_data;
            end

            if (i_in_valid && i_in_ready) begin
                ref_val  = i_in_data[LW-1:0];
                cand_val = i_in_data[2*LW-1:LW];
                diff = int'(cand_val) - int'(ref_val);
                mag = (diff < 0) ? -diff : diff;
                mag_wide = 64'(mag);
                sq = mag_wide * mag_wide;
                // zero length acts as one, anything above the maximum is clamped
                if (row_len == 0) begin
                    eff_len = 1;
                end else if (row_len > rec_pkg::ROW_LEN_MAX) begin
                    eff_len = 32'(rec_pkg::ROW_LEN_MAX);
                end else begin
                    eff_len = 32'(row_len);
                end

                if (sq > SUM_LIMIT - sq_sum) begin
                    sq_sum = SUM_LIMIT;
                end else begin
                    sq_sum = sq_sum + sq;
                end
                if (mag > abs_peak) begin
                    abs_peak = mag;
                end

                // first pair of a row seeds both maxima; ties keep the earlier index
                if (pair_count == 0) begin
                    ref_top = ref_val;
                    ref_idx = 0;
                    cand_top = cand_val;
                    cand_idx = 0;
                end else begin
                    if (ref_val > ref_top) begin
                        ref_top = ref_val;
                        ref_idx = pair_count;
                    end
                    if (cand_val > cand_top) begin
                        cand_top = cand_val;
                        cand_idx = pair_count;
                    end
                end

                if (pair_count + 1 >= eff_len) begin
                    mean = sq_sum / eff_len;
                    if (mean > MSE_LIMIT) begin
                        mean = MSE_LIMIT;
                    end
                    expected.mse   = mean[rec_pkg::MSE_W-1:0];
                    expected.peak  = (abs_peak > PEAK_LIMIT) ? PEAK_LIMIT[rec_pkg::PEAK_W-1:0]
                                                             : abs_peak[rec_pkg::PEAK_W-1:0];
                    expected.match = (ref_idx == cand_idx);
                    row_results_q.insert(row_results_q.size(), expected);
                    pair_count = 0;
                    sq_sum = 0;
                    abs_peak = 0;
                    ref_top = '0;
                    cand_top = '0;
                    ref_idx = 0;
                    cand_idx = 0;
                end else begin
                    pair_count++;
                end
            end
        end
        o_pending <= row_results_q.size();
    end

endmodule

@@ tb/sv/tb_row_error_and_argmax_compare_core.sv @@
`timescale 1ns / 1ps
// testbench top for the row error core: drives rows and config writes, gives the verdict
module tb_row_error_and_argmax_compare_core;

    localparam int RANDOM_ITEMS  = 950;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 2000000;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    logic [rec_pkg::LEN_W-1:0]          i_cfg_data = '0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    // ref_logit [15:0], cand_logit [31:16]
    logic [rec_pkg::IN_TDATA_W-1:0]     s_axis_tdata = '0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    // mean_sq_error [31:0], max_abs_error [47:32], top_match [48], zero fill above
    logic [rec_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;

    int          fail_count;
    int          pending;
    int          burst_left = 0;
    int          hold_reqs = 0;
    int          holds_done = 0;
    int          random_items = 0;
    int          cycle_count = 0;
    logic [15:0] last_logit = '0;

    row_error_and_argmax_compare_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    row_error_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // extremes, repeats of the previous value (ties), small values near zero and fully random values
    function automatic logic [15:0] pick_logit();
        logic [15:0] v;
        case ($urandom_range(0, 7))
            0:       v = 16'h8000;
            1:       v = 16'h7FFF;
            2, 3:    v = last_logit;
            4, 5:    v = 16'($urandom_range(0, 511) - 256);
            default: v = 16'($urandom);
        endcase
        last_logit = v;
        return v;
    endfunction

    // sender works in bursts with random gaps in between
    task automatic send_pair(input logic [15:0] ref_val, input logic [15:0] cand_val);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 32);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cand_val, ref_val};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_row_length(input logic [rec_pkg::LEN_W-1:0] len);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop offering pairs until every row result is back and the core has settled
    task automatic rest_until_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // receiver: stretches of different stall patterns, plus long hold-offs on request
    initial begin
        int mode;
        int stretch_left;
        mode = 0;
        stretch_left = 0;
        forever begin
            if (hold_reqs != holds_done) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holds_done++;
            end else begin
                if (stretch_left == 0) begin
                    mode = $urandom_range(0, 3);
                    stretch_left = $urandom_range(1, 80);
                end
                stretch_left--;
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    initial begin
        int len_sel;
        int row_len;
        int eff;
        int rows;
        int tail;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);

        // a partial row at the reset length, continued under a length above the max
        send_pair(16'h8000, 16'h7FFF);
        send_pair(16'h7FFF, 16'h8000);
        send_pair(16'h0000, 16'h0000);
        repeat (3) send_pair(pick_logit(), pick_logit());
        rest_until_drained();
        write_row_length(17'h1FFFF);
        repeat (2) send_pair(pick_logit(), pick_logit());
        rest_until_drained();

        // zero length behaves as one pair per row and closes the open row
        write_row_length(17'd0);
        send_pair(16'h8000, 16'h7FFF);
        send_pair(16'h7FFF, 16'h8000);
        send_pair(16'h0000, 16'h0000);
        rest_until_drained();
        write_row_length(17'd1);
        send_pair(16'hFFFF, 16'h0001);
        send_pair(16'h1234, 16'h1234);
        rest_until_drained();

        // argmax ties and all-negative rows
        write_row_length(17'd4);
        send_pair(16'd5, 16'd1);
        send_pair(16'd5, 16'd7);
        send_pair(16'd3, 16'd7);
        send_pair(16'd5, 16'd2);
        send_pair(16'd1, -16'sd3);
        send_pair(16'd9, 16'd4);
        send_pair(16'd9, 16'd4);
        send_pair(16'd0, -16'sd1);
        send_pair(-16'sd100, -16'sd300);
        send_pair(-16'sd50, -16'sd60);
        send_pair(-16'sd50, -16'sd10);
        send_pair(-16'sd200, -16'sd20);
        rest_until_drained();

        // length shrinks below the position mid-row, then grows mid-row
        write_row_length(17'd10);
        repeat (5) send_pair(pick_logit(), pick_logit());
        rest_until_drained();
        write_row_length(17'd3);
        send_pair(pick_logit(), pick_logit());
        rest_until_drained();
        write_row_length(17'd2);
        send_pair(pick_logit(), pick_logit());
        rest_until_drained();
        write_row_length(17'd5);
        repeat (4) send_pair(pick_logit(), pick_logit());
        rest_until_drained();

        // single-pair rows against a long receiver hold-off so the core backs up
        write_row_length(17'd1);
        hold_reqs <= hold_reqs + 1;
        repeat (40) send_pair(pick_logit(), pick_logit());
        rest_until_drained();

        while (random_items < RANDOM_ITEMS) begin
            len_sel = $urandom_range(0, 15);
            if (len_sel == 0) begin
                row_len = 0;
            end else if (len_sel == 1) begin
                row_len = 1;
            end else if (len_sel <= 3) begin
                row_len = $urandom_range(25, 130);
            end else begin
                row_len = $urandom_range(2, 24);
            end
            eff = (row_len == 0) ? 1 : row_len;
            write_row_length(rec_pkg::LEN_W'(row_len));
            rows = (eff > 24) ? $urandom_range(1, 2) : $urandom_range(1, 6);
            repeat (rows * eff) begin
                send_pair(pick_logit(), pick_logit());
                random_items++;
            end
            // sometimes leave a row open so the next length takes over mid-row
            if (eff > 1 && $urandom_range(0, 3) == 0) begin
                tail = $urandom_range(1, eff - 1);
                repeat (tail) begin
                    send_pair(pick_logit(), pick_logit());
                    random_items++;
                end
            end
            rest_until_drained();
        end

        rest_until_drained();
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ row_error_and_argmax_compare_core.f @@
rtl/rec_pkg.sv
rtl/rec_ctrl.sv
rtl/rec_acc.sv
rtl/rec_div.sv
rtl/row_error_and_argmax_compare_core.sv
tb/sv/row_error_checker.sv
tb/sv/tb_row_error_and_argmax_compare_core.sv
